/* design/sra_pkg.sv */
// ----------------------------------------------------------------------------
// Shelf rectangle allocator package
// Shared constants: default page geometry, field widths and the page limit.
// ----------------------------------------------------------------------------
package sra_pkg;

  // Default atlas page size in texels
  localparam int unsigned PAGE_WIDTH_DEF  = 1024;
  localparam int unsigned PAGE_HEIGHT_DEF = 1024;

  // Request and result field widths
  localparam int unsigned REQ_W  = 12;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned PAGE_W = 15;

  // Highest page number; the page counter saturates here
  localparam logic [PAGE_W-1:0] PAGE_MAX = {PAGE_W{1'b1}};

endpackage

/* design/shelf_rect_allocator_core.sv */
// ----------------------------------------------------------------------------
// Shelf rectangle allocator core
// Places rectangle requests into fixed-size atlas pages by row packing.
// ----------------------------------------------------------------------------
// One request word is taken per clock while in_stall is low, and one result
// word comes out per request. A request is captured in an input register and
// placed by a single pass of adds and compares against the cursor, row and
// page registers. The result moves into an output register when that is empty
// or being drained, and can be taken while out_stall is low. The placement
// state is updated in the same cycle the result is loaded, which sets the rate
// at one request per cycle while the output is not stalled.
// Placement tries, in order: the current row at the cursor, a new row below
// the current one, then a new page at origin 0,0 where an oversized request
// is clamped to the page and flagged. The page number saturates at its
// maximum. While a finished result waits for the consumer, the input register
// takes one more word and then stalls.
module shelf_rect_allocator_core #(
  parameter int unsigned PAGE_WIDTH  = sra_pkg::PAGE_WIDTH_DEF,
  parameter int unsigned PAGE_HEIGHT = sra_pkg::PAGE_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sra_pkg::REQ_W-1:0]   in_req_width,
  input  logic [sra_pkg::REQ_W-1:0]   in_req_height,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sra_pkg::POS_W-1:0]   out_rect_x,
  output logic [sra_pkg::POS_W-1:0]   out_rect_y,
  output logic [sra_pkg::SIZE_W-1:0]  out_rect_width,
  output logic [sra_pkg::SIZE_W-1:0]  out_rect_height,
  output logic [sra_pkg::PAGE_W-1:0]  out_page_number,
  output logic                        out_page_opened,
  output logic                        out_size_clamped
);

  // State widths follow the page size; sums get one bit over the widest term
  localparam int unsigned XW    = $clog2(PAGE_WIDTH + 1);
  localparam int unsigned YW    = $clog2(PAGE_HEIGHT + 1);
  localparam int unsigned MAXW  = (XW > YW) ? XW : YW;
  localparam int unsigned SUM_W =
    ((MAXW > sra_pkg::REQ_W) ? MAXW : sra_pkg::REQ_W) + 1;

  localparam logic [SUM_W-1:0] PW_S = SUM_W'(PAGE_WIDTH);
  localparam logic [SUM_W-1:0] PH_S = SUM_W'(PAGE_HEIGHT);

  // Input register
  logic                       in_valid_r;
  logic [sra_pkg::REQ_W-1:0]  req_width_r;
  logic [sra_pkg::REQ_W-1:0]  req_height_r;

  // Placement state
  logic [XW-1:0]              cursor_x_r;
  logic [YW-1:0]              row_top_r;
  logic [YW-1:0]              row_height_r;
  logic [sra_pkg::PAGE_W-1:0] current_page_r;
  logic                       any_page_open_r;

  // Output register
  logic                        out_valid_r;
  logic [sra_pkg::POS_W-1:0]   rect_x_r;
  logic [sra_pkg::POS_W-1:0]   rect_y_r;
  logic [sra_pkg::SIZE_W-1:0]  rect_width_r;
  logic [sra_pkg::SIZE_W-1:0]  rect_height_r;
  logic [sra_pkg::PAGE_W-1:0]  page_number_r;
  logic                        page_opened_r;
  logic                        size_clamped_r;

  // Next-value logic
  logic                       advance;
  logic [SUM_W-1:0]           w_ext;
  logic [SUM_W-1:0]           h_ext;
  logic [SUM_W-1:0]           cur_x_ext;
  logic [SUM_W-1:0]           top_ext;
  logic [SUM_W-1:0]           below_ext;
  logic                       fit_row;
  logic                       fit_below;
  logic                       w_over;
  logic                       h_over;
  logic [SUM_W-1:0]           w_place;
  logic [SUM_W-1:0]           h_place;
  logic [SUM_W-1:0]           x_place;
  logic [SUM_W-1:0]           y_place;
  logic [XW-1:0]              cursor_x_nxt;
  logic [YW-1:0]              row_top_nxt;
  logic [YW-1:0]              row_height_nxt;
  logic [sra_pkg::PAGE_W-1:0] current_page_nxt;
  logic                       opened_nxt;
  logic                       clamped_nxt;

  // Move a word from the input register to the output register when the
  // output is empty or being drained this cycle
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  // Place the request held in the input register
  always_comb begin
    // Zero size is treated as one texel
    w_ext = (req_width_r  == '0) ? SUM_W'(1) : SUM_W'(req_width_r);
    h_ext = (req_height_r == '0) ? SUM_W'(1) : SUM_W'(req_height_r);

    cur_x_ext = SUM_W'(cursor_x_r);
    top_ext   = SUM_W'(row_top_r);
    below_ext = SUM_W'(row_top_r) + SUM_W'(row_height_r);

    fit_row   = (cur_x_ext + w_ext <= PW_S) && (top_ext + h_ext <= PH_S);
    fit_below = (w_ext <= PW_S) && (below_ext + h_ext <= PH_S);
    w_over    = w_ext > PW_S;
    h_over    = h_ext > PH_S;

    cursor_x_nxt     = cursor_x_r;
    row_top_nxt      = row_top_r;
    row_height_nxt   = row_height_r;
    current_page_nxt = current_page_r;
    opened_nxt       = !any_page_open_r;
    clamped_nxt      = 1'b0;
    w_place          = w_ext;
    h_place          = h_ext;
    x_place          = '0;
    y_place          = '0;

    if (fit_row) begin
      // Extend the current row
      x_place      = cur_x_ext;
      y_place      = top_ext;
      cursor_x_nxt = XW'(cur_x_ext + w_ext);
      if (h_ext > SUM_W'(row_height_r)) begin
        row_height_nxt = YW'(h_ext);
      end
    end else if (fit_below) begin
      // Open a new row under the current one
      x_place        = '0;
      y_place        = below_ext;
      row_top_nxt    = YW'(below_ext);
      cursor_x_nxt   = XW'(w_ext);
      row_height_nxt = YW'(h_ext);
    end else begin
      // Open a new page, clamp oversized requests
      if (current_page_r != sra_pkg::PAGE_MAX) begin
        current_page_nxt = current_page_r + 1'b1;
      end
      opened_nxt  = 1'b1;
      clamped_nxt = w_over || h_over;
      if (w_over) begin
        w_place = PW_S;
      end
      if (h_over) begin
        h_place = PH_S;
      end
      row_top_nxt    = '0;
      cursor_x_nxt   = XW'(w_place);
      row_height_nxt = YW'(h_place);
    end
  end

  // Input register: load whenever it is empty or its word moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      req_width_r  <= in_req_width;
      req_height_r <= in_req_height;
    end
  end

  // Placement state: update once per placed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r      <= '0;
      row_top_r       <= '0;
      row_height_r    <= '0;
      current_page_r  <= '0;
      any_page_open_r <= 1'b0;
    end else if (advance) begin
      cursor_x_r      <= cursor_x_nxt;
      row_top_r       <= row_top_nxt;
      row_height_r    <= row_height_nxt;
      current_page_r  <= current_page_nxt;
      any_page_open_r <= 1'b1;
    end
  end

  // Output register: hold while stalled, drop the valid when drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      rect_x_r       <= sra_pkg::POS_W'(x_place);
      rect_y_r       <= sra_pkg::POS_W'(y_place);
      rect_width_r   <= sra_pkg::SIZE_W'(w_place);
      rect_height_r  <= sra_pkg::SIZE_W'(h_place);
      page_number_r  <= current_page_nxt;
      page_opened_r  <= opened_nxt;
      size_clamped_r <= clamped_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rect_x       = rect_x_r;
  assign out_rect_y       = rect_y_r;
  assign out_rect_width   = rect_width_r;
  assign out_rect_height  = rect_height_r;
  assign out_page_number  = page_number_r;
  assign out_page_opened  = page_opened_r;
  assign out_size_clamped = size_clamped_r;

endmodule

/* tb/shelf_placement_checker.sv */
// ----------------------------------------------------------------------------
// Shelf placement checker
// Watches the request and result channels of the shelf rectangle allocator.
// For each accepted request word it predicts the placement (row at the cursor,
// new row below, or new page with clamping) and queues it. Each accepted
// result word is compared field by field against the oldest queued placement.
// ----------------------------------------------------------------------------
module shelf_placement_checker #(
  parameter int unsigned PAGE_WIDTH  = sra_pkg::PAGE_WIDTH_DEF,
  parameter int unsigned PAGE_HEIGHT = sra_pkg::PAGE_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [sra_pkg::REQ_W-1:0]   in_req_width,
  input  logic [sra_pkg::REQ_W-1:0]   in_req_height,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [sra_pkg::POS_W-1:0]   out_rect_x,
  input  logic [sra_pkg::POS_W-1:0]   out_rect_y,
  input  logic [sra_pkg::SIZE_W-1:0]  out_rect_width,
  input  logic [sra_pkg::SIZE_W-1:0]  out_rect_height,
  input  logic [sra_pkg::PAGE_W-1:0]  out_page_number,
  input  logic                        out_page_opened,
  input  logic                        out_size_clamped,
  output int                          fail_count,
  output int                          pending
);
  import sra_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [PAGE_W-1:0] page;
    logic              opened;
    logic              clamped;
  } placement_t;

  // Shadow copy of the packing state
  logic [SIZE_W-1:0] cur_x;
  logic [SIZE_W-1:0] shelf_top;
  logic [SIZE_W-1:0] shelf_height;
  logic [PAGE_W-1:0] cur_page;
  logic              page_live;

  placement_t expected_placements[$];
  int         mismatches   = 0;
  int         results_seen = 0;

  assign fail_count = mismatches;
  assign pending    = expected_placements.size();

  // Print one mismatch line and count it
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Place one request and advance the shadow state
  task automatic place_request(input logic [REQ_W-1:0] req_w, input logic [REQ_W-1:0] req_h,
                               output placement_t p);
    int unsigned w;
    int unsigned h;
    w = (req_w == '0) ? 1 : req_w;
    h = (req_h == '0) ? 1 : req_h;
    p = '0;
    // the very first request opens page 0
    if (!page_live) begin
      page_live    = 1'b1;
      cur_x        = '0;
      shelf_top    = '0;
      shelf_height = '0;
      p.opened     = 1'b1;
    end
    if (cur_x + w <= PAGE_WIDTH && shelf_top + h <= PAGE_HEIGHT) begin
      // fits in the current row at the cursor
      p.x   = POS_W'(cur_x);
      p.y   = POS_W'(shelf_top);
      cur_x = SIZE_W'(cur_x + w);
      if (h > shelf_height) shelf_height = SIZE_W'(h);
    end else if (w <= PAGE_WIDTH && shelf_top + shelf_height + h <= PAGE_HEIGHT) begin
      // open a new row below the current one
      shelf_top    = SIZE_W'(shelf_top + shelf_height);
      p.x          = '0;
      p.y          = POS_W'(shelf_top);
      cur_x        = SIZE_W'(w);
      shelf_height = SIZE_W'(h);
    end else begin
      // new page at origin, saturating page count, clamp oversized requests
      if (cur_page < PAGE_MAX) cur_page = cur_page + 1'b1;
      p.opened = 1'b1;
      if (w > PAGE_WIDTH || h > PAGE_HEIGHT) begin
        p.clamped = 1'b1;
        if (w > PAGE_WIDTH) w = PAGE_WIDTH;
        if (h > PAGE_HEIGHT) h = PAGE_HEIGHT;
      end
      p.x          = '0;
      p.y          = '0;
      shelf_top    = '0;
      cur_x        = SIZE_W'(w);
      shelf_height = SIZE_W'(h);
    end
    p.width  = SIZE_W'(w);
    p.height = SIZE_W'(h);
    p.page   = cur_page;
  endtask

  // Compare one result word against the oldest prediction
  task automatic check_result();
    placement_t e;
    e = expected_placements.pop_front();
    if (out_rect_x !== e.x)
      report_mismatch($sformatf("result %0d rect_x got %0d expected %0d",
                                results_seen, out_rect_x, e.x));
    if (out_rect_y !== e.y)
      report_mismatch($sformatf("result %0d rect_y got %0d expected %0d",
                                results_seen, out_rect_y, e.y));
    if (out_rect_width !== e.width)
      report_mismatch($sformatf("result %0d rect_width got %0d expected %0d",
                                results_seen, out_rect_width, e.width));
    if (out_rect_height !== e.height)
      report_mismatch($sformatf("result %0d rect_height got %0d expected %0d",
                                results_seen, out_rect_height, e.height));
    if (out_page_number !== e.page)
      report_mismatch($sformatf("result %0d page_number got %0d expected %0d",
                                results_seen, out_page_number, e.page));
    if (out_page_opened !== e.opened)
      report_mismatch($sformatf("result %0d page_opened got %0b expected %0b",
                                results_seen, out_page_opened, e.opened));
    if (out_size_clamped !== e.clamped)
      report_mismatch($sformatf("result %0d size_clamped got %0b expected %0b",
                                results_seen, out_size_clamped, e.clamped));
  endtask

  // Watch both channels at each rising edge
  always @(posedge clk) begin
    placement_t p;
    if (!rst_n) begin
      cur_x        = '0;
      shelf_top    = '0;
      shelf_height = '0;
      cur_page     = '0;
      page_live    = 1'b0;
      expected_placements.delete();
    end else begin
      if (in_valid && !in_stall) begin
        place_request(in_req_width, in_req_height, p);
        expected_placements = {expected_placements, p};
      end
      if (out_valid && !out_stall) begin
        if (expected_placements.size() == 0)
          report_mismatch($sformatf("result %0d arrived with no request waiting",
                                    results_seen));
        else
          check_result();
        results_seen++;
      end
    end
  end

endmodule

/* tb/tb_shelf_rect_allocator_core.sv */
// ----------------------------------------------------------------------------
// Shelf rectangle allocator testbench
// Drives directed edge requests, random shelf-packing mixes with idle and
// stall bursts on both channels, and a back-to-back run of page-filling
// requests. A checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_shelf_rect_allocator_core;
  import sra_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 10;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int FILL_ITEMS     = 100;
  localparam int AFTER_ITEMS    = 30;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic [REQ_W-1:0]   in_req_width  = '0;
  logic [REQ_W-1:0]   in_req_height = '0;
  logic               out_stall     = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [POS_W-1:0]   out_rect_x;
  logic [POS_W-1:0]   out_rect_y;
  logic [SIZE_W-1:0]  out_rect_width;
  logic [SIZE_W-1:0]  out_rect_height;
  logic [PAGE_W-1:0]  out_page_number;
  logic               out_page_opened;
  logic               out_size_clamped;
  int                 fail_count;
  int                 pending;

  bit quiet    = 1'b0;
  int idle_pct = 20;
  int sent     = 0;
  int stall_left  = 0;
  int run_left    = 0;
  int idle_cycles = 0;

  shelf_rect_allocator_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_width     (in_req_width),
    .in_req_height    (in_req_height),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rect_x       (out_rect_x),
    .out_rect_y       (out_rect_y),
    .out_rect_width   (out_rect_width),
    .out_rect_height  (out_rect_height),
    .out_page_number  (out_page_number),
    .out_page_opened  (out_page_opened),
    .out_size_clamped (out_size_clamped)
  );

  shelf_placement_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_width     (in_req_width),
    .in_req_height    (in_req_height),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rect_x       (out_rect_x),
    .out_rect_y       (out_rect_y),
    .out_rect_width   (out_rect_width),
    .out_rect_height  (out_rect_height),
    .out_page_number  (out_page_number),
    .out_page_opened  (out_page_opened),
    .out_size_clamped (out_size_clamped),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Clock: 8 time units
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: random stall bursts between unstalled runs of varying length
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (run_left > 0) begin
      out_stall <= 1'b0;
      run_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = $urandom_range(1, 19);
      run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 25);
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one request word, optionally after an idle burst, and hold it until taken
  task automatic push_request(input logic [REQ_W-1:0] w, input logic [REQ_W-1:0] h);
    if (!quiet && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_width  <= w;
    in_req_height <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Hold off the sender until every predicted result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random side length: mostly small so rows and pages fill, some edges and oversize
  function automatic logic [REQ_W-1:0] random_side();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return REQ_W'($urandom_range(1, 64));
    if (pick < 75) return REQ_W'($urandom_range(1, 256));
    if (pick < 85) return REQ_W'($urandom_range(1, 1024));
    if (pick < 92) begin
      case ($urandom_range(0, 6))
        0: return '0;
        1: return REQ_W'(1);
        2: return REQ_W'(1023);
        3: return REQ_W'(1024);
        4: return REQ_W'(1025);
        5: return REQ_W'(2048);
        default: return '1;
      endcase
    end
    return REQ_W'($urandom_range(0, 4095));
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: oversized first request, zero sizes, exact fits, clamping
    push_request(12'hFFF, 12'hFFF);
    push_request(12'h000, 12'h000);
    push_request(12'h000, 12'hFFF);
    push_request(12'hFFF, 12'h000);
    push_request(12'd1024, 12'd1024);
    push_request(12'd1, 12'd1);
    push_request(12'd1022, 12'd1);
    push_request(12'd1, 12'd5);
    push_request(12'd1024, 12'd1);
    push_request(12'd1025, 12'd5);
    push_request(12'd512, 12'd512);
    push_request(12'd512, 12'd256);
    push_request(12'd512, 12'd256);
    push_request(12'd512, 12'd256);
    push_request(12'd1, 12'd1);
    push_request(12'd4094, 12'd2);
    push_request(12'd2, 12'd4094);
    push_request(12'd1024, 12'd1023);
    push_request(12'd1024, 12'd1);
    push_request(12'd1, 12'd1);
    push_request(12'h800, 12'h555);
    push_request(12'h2AA, 12'h7FF);
    push_request(12'd1, 12'd1024);
    push_request(12'd1023, 12'd1024);

    // Let everything drain before the random part
    drain_results();

    // Random mixes; the idle rate changes every 64 words, zero included
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      if (i == RANDOM_ITEMS / 2) drain_results();
      push_request(random_side(), random_side());
    end

    // Fill pages back to back with no idling on either side
    quiet = 1'b1;
    for (int i = 0; i < FILL_ITEMS; i++) begin
      if (i % 9 == 4) push_request(12'hFFF, REQ_W'($urandom_range(0, 4095)));
      else push_request(12'd1024, 12'd1024);
    end
    for (int i = 0; i < AFTER_ITEMS; i++)
      push_request(random_side(), random_side());

    // Wait for the last results and a short tail
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests: edge sizes, zero sizes, rows, new rows, clamping,", sent);
    $display("random packing under stalls and idles, and back-to-back page opening");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
design/sra_pkg.sv
design/shelf_rect_allocator_core.sv
tb/shelf_placement_checker.sv
tb/tb_shelf_rect_allocator_core.sv
